/* rtl/core/spiq_pkg.sv */
// ----------------------------------------------------------------------------
// spiq_pkg
// shared types and constants of the sorted priority insert queue
// ----------------------------------------------------------------------------
package spiq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int PRIO_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic [PRIO_W-1:0] MAX_PRIORITY = 3'd5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DUMP   = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_EMPTY,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic capture;
      logic insert;
      logic empty_rsp;
      logic dump_start;
      logic dump_rsp;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic dump_last;
   } stat_type;

endpackage

/* rtl/core/spiq_ctrl.sv */
// ----------------------------------------------------------------------------
// spiq_ctrl
// sequencer: accepts a transaction, runs an insert or a dump over the store
// ----------------------------------------------------------------------------
module spiq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_operation,
   input  spiq_pkg::stat_type stat,
   output spiq_pkg::cmd_type cmd,
   output logic              busy,
   output logic              rsp_valid
);

   spiq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spiq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spiq_pkg::ST_IDLE: begin
            if (start) begin
               if (req_operation == spiq_pkg::OP_INSERT) begin
                  state_in = spiq_pkg::ST_INSERT;
               end else if (stat.count_zero) begin
                  state_in = spiq_pkg::ST_EMPTY;
               end else begin
                  state_in = spiq_pkg::ST_DUMP;
               end
            end
         end
         spiq_pkg::ST_INSERT: state_in = spiq_pkg::ST_IDLE;
         spiq_pkg::ST_EMPTY:  state_in = spiq_pkg::ST_IDLE;
         spiq_pkg::ST_DUMP: begin
            if (stat.dump_last) begin
               state_in = spiq_pkg::ST_IDLE;
            end
         end
         default: state_in = spiq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         spiq_pkg::ST_IDLE: begin
            busy           = 1'b0;
            cmd.capture    = start;
            cmd.dump_start = start;
         end
         spiq_pkg::ST_INSERT: begin
            cmd.insert = 1'b1;
            rsp_valid  = 1'b1;
         end
         spiq_pkg::ST_EMPTY: begin
            cmd.empty_rsp = 1'b1;
            rsp_valid     = 1'b1;
         end
         spiq_pkg::ST_DUMP: begin
            cmd.dump_rsp = 1'b1;
            rsp_valid    = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

/* rtl/core/spiq_datapath.sv */
// ----------------------------------------------------------------------------
// spiq_datapath
// sorted entry chain, request capture, dump pointer and result fields
// ----------------------------------------------------------------------------
module spiq_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  spiq_pkg::cmd_type                 cmd,
   input  logic [spiq_pkg::PRIO_W-1:0]       req_priority_req,
   input  logic signed [spiq_pkg::DATA_W-1:0] req_payload,
   output spiq_pkg::stat_type                stat,
   output logic [1:0]                        rsp_status,
   output logic [spiq_pkg::PRIO_W-1:0]       rsp_entry_priority,
   output logic signed [spiq_pkg::DATA_W-1:0] rsp_entry_data,
   output logic                              rsp_last
);

   localparam int DEPTH = spiq_pkg::QUEUE_DEPTH;

   logic [spiq_pkg::PRIO_W-1:0] prio_ff [DEPTH];
   logic [spiq_pkg::PRIO_W-1:0] prio_in [DEPTH];
   logic [spiq_pkg::DATA_W-1:0] data_ff [DEPTH];
   logic [spiq_pkg::DATA_W-1:0] data_in [DEPTH];
   logic [spiq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [spiq_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [spiq_pkg::PRIO_W-1:0] new_prio_ff, new_prio_in;
   logic [spiq_pkg::DATA_W-1:0] new_data_ff, new_data_in;

   logic [DEPTH-1:0]     le;
   logic                 invalid;
   logic                 full;
   logic                 write_en;
   spiq_pkg::status_type ins_status;

   assign invalid  = new_prio_ff > spiq_pkg::MAX_PRIORITY;
   assign full     = count_ff == spiq_pkg::CNT_W'(DEPTH);
   assign write_en = cmd.insert && !invalid && !full;

   always_comb begin
      if (invalid) begin
         ins_status = spiq_pkg::STATUS_INVALID;
      end else if (full) begin
         ins_status = spiq_pkg::STATUS_FULL;
      end else begin
         ins_status = spiq_pkg::STATUS_OK;
      end
   end

   // entries at or below the new priority stay, the first one above takes it
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le[i] = (count_ff > spiq_pkg::CNT_W'(i)) && (prio_ff[i] <= new_prio_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         prio_in[i] = prio_ff[i];
         data_in[i] = data_ff[i];
         if (write_en && !le[i]) begin
            if (i == 0) begin
               prio_in[i] = new_prio_ff;
               data_in[i] = new_data_ff;
            end else if (le[i-1]) begin
               prio_in[i] = new_prio_ff;
               data_in[i] = new_data_ff;
            end else begin
               prio_in[i] = prio_ff[i-1];
               data_in[i] = data_ff[i-1];
            end
         end
      end
   end

   always_comb begin
      count_in    = count_ff;
      idx_in      = idx_ff;
      new_prio_in = new_prio_ff;
      new_data_in = new_data_ff;
      if (cmd.capture) begin
         new_prio_in = req_priority_req;
         new_data_in = req_payload;
      end
      if (write_en) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.dump_start) begin
         idx_in = '0;
      end else if (cmd.dump_rsp) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         prio_ff[i] <= prio_in[i];
         data_ff[i] <= data_in[i];
      end
      idx_ff      <= idx_in;
      new_prio_ff <= new_prio_in;
      new_data_ff <= new_data_in;
   end

   assign stat.count_zero = count_ff == '0;
   assign stat.dump_last  = {1'b0, idx_ff} == (count_ff - 1'b1);

   always_comb begin
      rsp_status         = 2'(spiq_pkg::STATUS_OK);
      rsp_entry_priority = '0;
      rsp_entry_data     = '0;
      rsp_last           = 1'b1;
      if (cmd.insert) begin
         rsp_status = 2'(ins_status);
      end else if (cmd.empty_rsp) begin
         rsp_status = 2'(spiq_pkg::STATUS_EMPTY);
      end else if (cmd.dump_rsp) begin
         rsp_entry_priority = prio_ff[idx_ff];
         rsp_entry_data     = data_ff[idx_ff];
         rsp_last           = stat.dump_last;
      end
   end

endmodule

/* rtl/core/sorted_priority_insert_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_insert_queue
// bounded queue of (priority, data) entries kept in ascending priority order
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_operation, req_priority_req,        start & !busy
//            req_payload
//  response  rsp_status, rsp_entry_priority,         rsp_valid, one cycle
//            rsp_entry_data, rsp_last
//
//  an insert captures the request, then the entry chain shifts and the
//  status is strobed. a dump captures the request, then reads out one
//  entry per cycle from the chain by the dump pointer, or strobes empty.
//  reset clears the entry count; entry contents are left as they were.
//  the receiver cannot stall; busy stays high until the last response.
// ----------------------------------------------------------------------------
module sorted_priority_insert_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_operation,
   input  logic [spiq_pkg::PRIO_W-1:0]        req_priority_req,
   input  logic signed [spiq_pkg::DATA_W-1:0] req_payload,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [spiq_pkg::PRIO_W-1:0]        rsp_entry_priority,
   output logic signed [spiq_pkg::DATA_W-1:0] rsp_entry_data,
   output logic                               rsp_last
);

   spiq_pkg::cmd_type  cmd;
   spiq_pkg::stat_type stat;

   spiq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid)
   );

   spiq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_priority_req   (req_priority_req),
      .req_payload        (req_payload),
      .stat               (stat),
      .rsp_status         (rsp_status),
      .rsp_entry_priority (rsp_entry_priority),
      .rsp_entry_data     (rsp_entry_data),
      .rsp_last           (rsp_last)
   );

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench for sorted_priority_insert_queue
// drives insert and dump transactions in random bursts, keeps a shadow copy of
// the sorted entry chain and checks every strobed response against it
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 220;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct {
      logic [1:0]                  status;
      logic [spiq_pkg::PRIO_W-1:0] prio;
      logic [spiq_pkg::DATA_W-1:0] data;
      logic                        last;
   } readout_type;

   // shadow of the sorted entry chain plus the responses still owed
   class priority_queue_shadow;
      logic [spiq_pkg::PRIO_W-1:0] prio_chain [spiq_pkg::QUEUE_DEPTH];
      logic [spiq_pkg::DATA_W-1:0] data_chain [spiq_pkg::QUEUE_DEPTH];
      int                          entry_count;
      readout_type                 pending_readouts [$];
      int                          errors;
      int                          n_stored;
      int                          n_invalid;
      int                          n_full;
      int                          n_empty;
      int                          n_dumped;

      function new();
         entry_count = 0;
         errors      = 0;
         n_stored    = 0;
         n_invalid   = 0;
         n_full      = 0;
         n_empty     = 0;
         n_dumped    = 0;
      endfunction

      function void owe(logic [1:0] status, logic [spiq_pkg::PRIO_W-1:0] prio,
                        logic [spiq_pkg::DATA_W-1:0] data, logic last);
         readout_type r;
         r.status = status;
         r.prio   = prio;
         r.data   = data;
         r.last   = last;
         pending_readouts.push_back(r);
      endfunction

      function void note_command(logic op, logic [spiq_pkg::PRIO_W-1:0] prio,
                                 logic [spiq_pkg::DATA_W-1:0] payload);
         int pos;
         if (op == spiq_pkg::OP_INSERT) begin
            // the priority check wins over the full check
            if (prio > spiq_pkg::MAX_PRIORITY) begin
               owe(spiq_pkg::STATUS_INVALID, '0, '0, 1'b1);
               n_invalid++;
            end else if (entry_count >= spiq_pkg::QUEUE_DEPTH) begin
               owe(spiq_pkg::STATUS_FULL, '0, '0, 1'b1);
               n_full++;
            end else begin
               // new entry goes behind every entry of lower or equal priority
               pos = 0;
               while (pos < entry_count && prio_chain[pos] <= prio) pos++;
               for (int i = entry_count; i > pos; i--) begin
                  prio_chain[i] = prio_chain[i-1];
                  data_chain[i] = data_chain[i-1];
               end
               prio_chain[pos] = prio;
               data_chain[pos] = payload;
               entry_count++;
               owe(spiq_pkg::STATUS_OK, '0, '0, 1'b1);
               n_stored++;
            end
         end else if (entry_count == 0) begin
            owe(spiq_pkg::STATUS_EMPTY, '0, '0, 1'b1);
            n_empty++;
         end else begin
            for (int i = 0; i < entry_count; i++) begin
               owe(spiq_pkg::STATUS_OK, prio_chain[i], data_chain[i],
                   i == entry_count - 1);
               n_dumped++;
            end
         end
      endfunction

      function void check_readout(logic [1:0] status, logic [spiq_pkg::PRIO_W-1:0] prio,
                                  logic [spiq_pkg::DATA_W-1:0] data, logic last);
         readout_type want;
         if (pending_readouts.size() == 0) begin
            $error("unexpected response: status %0d entry_priority %0d entry_data %0h",
                   status, prio, data);
            errors++;
            return;
         end
         want = pending_readouts.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
         end
         if (prio !== want.prio) begin
            $error("entry_priority: expected %0d, got %0d", want.prio, prio);
            errors++;
         end
         if (data !== want.data) begin
            $error("entry_data: expected %0h, got %0h", want.data, data);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic                                req_operation = spiq_pkg::OP_INSERT;
   logic [spiq_pkg::PRIO_W-1:0]         req_priority_req = '0;
   logic signed [spiq_pkg::DATA_W-1:0]  req_payload = '0;
   logic                                rsp_valid;
   logic [1:0]                          rsp_status;
   logic [spiq_pkg::PRIO_W-1:0]         rsp_entry_priority;
   logic signed [spiq_pkg::DATA_W-1:0]  rsp_entry_data;
   logic                                rsp_last;

   priority_queue_shadow shadow;
   int                   idle_cycles = 0;

   sorted_priority_insert_queue u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_priority_req   (req_priority_req),
      .req_payload        (req_payload),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_entry_priority (rsp_entry_priority),
      .rsp_entry_data     (rsp_entry_data),
      .rsp_last           (rsp_last)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // responses are checked before the transaction taken on the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            shadow.check_readout(rsp_status, rsp_entry_priority, rsp_entry_data, rsp_last);
         if (start && !busy)
            shadow.note_command(req_operation, req_priority_req, req_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic issue_command(input logic op, input logic [spiq_pkg::PRIO_W-1:0] prio,
                                input logic [spiq_pkg::DATA_W-1:0] payload);
      start            <= 1'b1;
      req_operation    <= op;
      req_priority_req <= prio;
      req_payload      <= payload;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic issue_random();
      logic op;
      op = ($urandom_range(0, 99) < 35) ? spiq_pkg::OP_DUMP : spiq_pkg::OP_INSERT;
      issue_command(op, spiq_pkg::PRIO_W'($urandom_range(0, 7)),
                    spiq_pkg::DATA_W'($urandom));
   endtask

   initial begin
      int remaining;
      int burst;

      shadow = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty store, invalid priorities, extremes and ties at both ends
      issue_command(spiq_pkg::OP_DUMP,   3'd0, 32'h0000_0000);
      issue_command(spiq_pkg::OP_INSERT, 3'd7, 32'h1234_5678);
      issue_command(spiq_pkg::OP_INSERT, 3'd6, 32'hffff_ffff);
      issue_command(spiq_pkg::OP_DUMP,   3'd0, 32'h0000_0000);
      issue_command(spiq_pkg::OP_INSERT, 3'd5, 32'h7fff_ffff);
      issue_command(spiq_pkg::OP_INSERT, 3'd0, 32'h8000_0000);
      issue_command(spiq_pkg::OP_DUMP,   3'd7, 32'hffff_ffff);
      idle_gap(3);
      issue_command(spiq_pkg::OP_INSERT, 3'd0, 32'hffff_ffff);
      issue_command(spiq_pkg::OP_INSERT, 3'd2, 32'h5555_5555);
      issue_command(spiq_pkg::OP_INSERT, 3'd2, 32'haaaa_aaaa);
      issue_command(spiq_pkg::OP_INSERT, 3'd5, 32'h0000_0000);
      issue_command(spiq_pkg::OP_INSERT, 3'd3, 32'h0000_0001);
      issue_command(spiq_pkg::OP_INSERT, 3'd1, 32'hdead_beef);
      issue_command(spiq_pkg::OP_INSERT, 3'd4, 32'h0f0f_f0f0);
      issue_command(spiq_pkg::OP_DUMP,   3'd0, 32'h0000_0000);

      // random bursts; the store fills up and then sees full and invalid inserts
      remaining = RANDOM_ITEMS;
      while (remaining > 0) begin
         burst = $urandom_range(1, 12);
         for (int j = 0; j < burst && remaining > 0; j++) begin
            issue_random();
            remaining--;
         end
         idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
      start <= 1'b0;

      while (shadow.pending_readouts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered: %0d stored, %0d invalid, %0d full, %0d empty dumps",
               shadow.n_stored, shadow.n_invalid, shadow.n_full, shadow.n_empty);
      $display("covered: %0d entries read out, %0d mismatches",
               shadow.n_dumped, shadow.errors);
      if (shadow.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
